>>> src/frac_red_pkg.sv
// package for the fraction reducer: controller state type and command/status structs
// no dependencies
package frac_red_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture request, start magnitudes
    logic gcd_start;  // load gcd operands
    logic gcd_step;   // one binary-gcd step
    logic div_start;  // load divider for numerator or denominator
    logic div_sel_d;  // 0: numerator, 1: denominator
    logic div_step;   // one restoring division bit
    logic finish;     // form result registers
  } cmd_t;

  typedef struct packed {
    logic both_zero;
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage

>>> src/frac_red_ctrl.sv
// controller state machine for the fraction reducer
// depends on frac_red_pkg
module frac_red_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output frac_red_pkg::cmd_t     cmd,
  input  frac_red_pkg::status_t  status
);
  import frac_red_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  // one item at a time; a result may wait in the output register while the next item works
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = status.both_zero ? ST_DONE : ST_GCD;
      ST_GCD:  if (status.gcd_done) state_next = ST_DIVN;
      ST_DIVN: if (status.div_done) state_next = ST_DIVD;
      ST_DIVD: if (status.div_done) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = accept;
      end
      ST_GCD: begin
        cmd.gcd_step = !status.gcd_done;
        cmd.div_start = status.gcd_done;
      end
      ST_DIVN: begin
        cmd.div_step = !status.div_done;
        cmd.div_start = status.div_done;
        cmd.div_sel_d = status.div_done;
      end
      ST_DIVD: begin
        cmd.div_sel_d = 1'b1;
        cmd.div_step = !status.div_done;
      end
      ST_DONE: cmd.finish = !out_valid || !out_stall;
      default: ;
    endcase
    cmd.gcd_start = cmd.load;
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cmd.finish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> src/frac_red_dp.sv
// datapath for the fraction reducer: magnitudes, binary gcd, bit-serial divider, result regs
// depends on frac_red_pkg
module frac_red_dp #(
  parameter int WORD_BITS = 64
) (
  input  logic                   clk,
  input  logic [63:0]            numerator_in,
  input  logic [63:0]            denominator_in,
  input  frac_red_pkg::cmd_t     cmd,
  output frac_red_pkg::status_t  status,
  output logic [63:0]            numerator_out,
  output logic [62:0]            denominator_out,
  output logic [62:0]            common_divisor,
  output logic                   zero_over_zero
);
  import frac_red_pkg::*;

  localparam int W = WORD_BITS;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]  in_n, in_d, abs_n, abs_d;
  logic [W-1:0]  mag_n, mag_d;
  logic          neg;
  logic [W-1:0]  ga, gb;
  logic [CW-1:0] shift;
  logic [W-1:0]  g;
  logic [W-1:0]  quo, rem, dvd;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rn;
  logic [W:0]    trial;
  logic [W-1:0]  g_sat, rd_sat, num_val;

  assign in_n = numerator_in[W-1:0];
  assign in_d = denominator_in[W-1:0];
  assign abs_n = in_n[W-1] ? (~in_n + 1'b1) : in_n;
  assign abs_d = in_d[W-1] ? (~in_d + 1'b1) : in_d;

  assign status.both_zero = (abs_n == '0) && (abs_d == '0);
  // binary gcd ends when one operand is zero; result is the other shifted back
  assign status.gcd_done = (ga == '0) || (gb == '0);
  assign g = ((ga == '0) ? gb : ga) << shift;
  assign status.div_done = (cnt == '0);

  assign trial = {rem, dvd[W-1]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_n <= abs_n;
      mag_d <= abs_d;
      neg <= in_n[W-1] ^ in_d[W-1];
    end
    if (cmd.gcd_start) begin
      ga <= abs_n;
      gb <= abs_d;
      shift <= '0;
    end else if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        shift <= shift + 1'b1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end
    if (cmd.div_start) begin
      dvd <= cmd.div_sel_d ? mag_d : mag_n;
      rem <= '0;
      quo <= '0;
      cnt <= CW'(W);
      if (cmd.div_sel_d) rn <= quo;
    end else if (cmd.div_step) begin
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], dvd[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign g_sat  = (g > MAX_POS) ? MAX_POS : g;
  assign rd_sat = (quo > MAX_POS) ? MAX_POS : quo;
  assign num_val = neg ? (~rn + 1'b1) : ((rn > MAX_POS) ? MAX_POS : rn);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (status.gcd_done && mag_n == '0 && mag_d == '0) begin
        numerator_out <= '0;
        denominator_out <= 63'd1;
        common_divisor <= '0;
        zero_over_zero <= 1'b1;
      end else begin
        zero_over_zero <= 1'b0;
        common_divisor <= 63'(g_sat);
        if (rn == '0) begin
          numerator_out <= '0;
          denominator_out <= 63'd1;
        end else begin
          numerator_out <= 64'($signed(num_val));
          denominator_out <= 63'(rd_sat);
        end
      end
    end
  end

endmodule

>>> src/fraction_reducer_top.sv
// top level of the fraction reducer: controller plus datapath
// depends on frac_red_pkg, frac_red_ctrl, frac_red_dp
//
// channel   direction  handshake            payload
// request   in         in_valid / in_stall  numerator_in, denominator_in
// result    out        out_valid / out_stall numerator_out, denominator_out,
//                                           common_divisor, zero_over_zero
//
// one request at a time: accept, then binary-gcd steps and a done step, then bit-serial
// restoring division of the numerator and then the denominator by the gcd, and a finish
// step that fills the result registers
// a 0/0 request skips the gcd and both divisions and goes straight to the finish step
// the gcd step loop and the restoring divider set how long a request takes
// rst is synchronous active high and clears only control state
// a stalled result holds in the output register; the next request is taken
// once it has been moved there
module fraction_reducer_top #(
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] numerator_in,
  input  logic [63:0] denominator_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] numerator_out,
  output logic [62:0] denominator_out,
  output logic [62:0] common_divisor,
  output logic        zero_over_zero
);
  import frac_red_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing of gcd, two divisions and result capture
  frac_red_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // magnitudes, gcd hardware, one divider shared by both divisions, result registers
  frac_red_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk             (clk),
    .numerator_in    (numerator_in),
    .denominator_in  (denominator_in),
    .cmd             (cmd),
    .status          (status),
    .numerator_out   (numerator_out),
    .denominator_out (denominator_out),
    .common_divisor  (common_divisor),
    .zero_over_zero  (zero_over_zero)
  );

endmodule
